// ===== hw/rtl/bilinear_texture_sampler_core_assert.svh =====
// Assertion macros for the texture sampler core.
// Each macro expects clk and rst_n in scope.
`ifndef BILINEAR_TEXTURE_SAMPLER_CORE_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

    // Default texture limits and gamma table geometry (table size is a power of two)
    localparam int MaxWidthDef    = 256;
    localparam int MaxHeightDef   = 256;
    localparam int GammaTableSize = 256;
    localparam int GammaBits      = $clog2(GammaTableSize);
    localparam int HalfStepDen    = 131070;
    localparam int TexelBits      = 32;

    // Configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 9;
    localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgSrgb   = 2'd2;

    // Opcodes
    localparam logic [1:0] OpStore  = 2'd0;
    localparam logic [1:0] OpLoad   = 2'd1;
    localparam logic [1:0] OpSample = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
        logic [17:0]        red_in;
        logic [17:0]        green_in;
        logic [17:0]        blue_in;
        logic [17:0]        alpha_in;
    } bts_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
        logic        error;
    } bts_out_t;

    // Controller to datapath
    typedef struct packed {
        logic       cap_in;
        logic       decode;
        logic       wrap_start;
        logic       wrap_step;
        logic       wrap_fix;
        logic       base;
        logic       rd_en;
        logic [1:0] rd_idx;
        logic       acc_en;
        logic       gamma;
        logic       mem_wr;
        logic       out_load;
    } bts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       oob;
    } bts_stat_t;

    // Extended-precision number used only to build the gamma tables
    typedef struct packed {
        logic [63:0]        m;
        logic signed [31:0] e;
    } xnum_t;

    typedef logic [15:0] gamma_tab_t [GammaTableSize+1];

    function automatic xnum_t xn_norm(logic [63:0] m, int e);
        xnum_t       r;
        logic [63:0] mm;
        int          ee;
        mm = m;
        ee = e;
        if (mm == 64'd0) begin
            r.m = 64'd0;
            r.e = 32'sd0;
        end else begin
            while (mm >= 64'h1_0000_0000) begin
                mm = mm >> 1;
                ee = ee - 1;
            end
            while (mm < 64'h8000_0000) begin
                mm = mm << 1;
                ee = ee + 1;
            end
            r.m = mm;
            r.e = ee;
        end
        return r;
    endfunction

    function automatic xnum_t xn_mul(xnum_t a, xnum_t b);
        if (a.m == 64'd0 || b.m == 64'd0) begin
            return xn_norm(64'd0, 0);
        end
        return xn_norm(a.m * b.m, int'(a.e) + int'(b.e));
    endfunction

    function automatic xnum_t xn_pow(xnum_t a, int k);
        xnum_t r;
        r = a;
        for (int i = 1; i < k; i++) begin
            r = xn_mul(r, a);
        end
        return r;
    endfunction

    function automatic logic xn_le(xnum_t a, xnum_t b);
        if (a.m == 64'd0) begin
            return 1'b1;
        end
        if (b.m == 64'd0) begin
            return 1'b0;
        end
        if (a.e != b.e) begin
            return a.e > b.e;
        end
        return a.m <= b.m;
    endfunction

    function automatic xnum_t ratio_tab(logic [63:0] p);
        return xn_norm((p << 32) / 64'(GammaTableSize), 32);
    endfunction

    function automatic xnum_t ratio_half(logic [63:0] p);
        return xn_norm((p << 32) / 64'(HalfStepDen), 32);
    endfunction

    // Entry i: largest y whose lower rounding bound raised to den stays within (i/N)^num
    function automatic gamma_tab_t build_table(int num, int den);
        gamma_tab_t t;
        xnum_t      target;
        xnum_t      bound;
        int         lo;
        int         hi;
        int         mid;
        for (int i = 0; i <= GammaTableSize; i++) begin
            target = xn_pow(ratio_tab(64'(i)), num);
            lo = 0;
            hi = 65535;
            while (lo < hi) begin
                mid   = (lo + hi + 1) >> 1;
                bound = xn_pow(ratio_half(64'(2 * mid - 1)), den);
                if (xn_le(bound, target)) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            t[i] = 16'(lo);
        end
        return t;
    endfunction

    localparam gamma_tab_t GamFwd = build_table(11, 5);
    localparam gamma_tab_t GamInv = build_table(5, 11);

    // Interpolated curve lookup; inv selects gamma 1/2.2, else 2.2
    function automatic logic [15:0] curve(logic inv, logic [15:0] x);
        logic [GammaBits:0] ia;
        logic [GammaBits:0] ib;
        logic [15:0]        fr;
        logic [15:0]        a;
        logic [15:0]        b;
        logic [31:0]        prod;
        ia   = {1'b0, x[15 -: GammaBits]};
        ib   = ia + 1'b1;
        fr   = 16'(x << GammaBits);
        a    = inv ? GamInv[ia] : GamFwd[ia];
        b    = inv ? GamInv[ib] : GamFwd[ib];
        if (b < a) begin
            b = a;
        end
        prod = 32'(b - a) * 32'(fr);
        return a + prod[31:16];
    endfunction

endpackage

// ===== hw/rtl/bts_ram.sv =====
`timescale 1ns / 1ps

module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bts_wrap.sv =====
`timescale 1ns / 1ps

module bts_wrap #(
    parameter int NW = 9,
    parameter int FW = 18
) (
    input  logic                 clk,
    input  logic                 start,
    input  logic                 step,
    input  logic                 fix,
    input  logic signed [FW-1:0] fl,
    input  logic                 fnz,
    input  logic [NW-1:0]        n,
    output logic [NW-1:0]        i0,
    output logic [NW-1:0]        i1
);

    logic [FW-1:0] mag_reg;
    logic [NW-1:0] rem_reg;
    logic          neg_reg;
    logic          fnz_reg;
    logic [NW-1:0] i0_reg;
    logic [NW-1:0] i1_reg;
    logic [NW:0]   trial;
    logic [NW-1:0] i0_next;
    logic [NW-1:0] i1_next;

    // Restoring remainder, one dividend bit per step
    assign trial = {rem_reg, mag_reg[FW-1]};

    always_comb
    begin
        if (neg_reg && rem_reg != '0)
        begin
            i0_next = n - rem_reg;
        end
        else
        begin
            i0_next = rem_reg;
        end
        if (!fnz_reg)
        begin
            i1_next = i0_next;
        end
        else if (i0_next + 1'b1 == n)
        begin
            i1_next = '0;
        end
        else
        begin
            i1_next = i0_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= fl[FW-1];
            mag_reg <= fl[FW-1] ? FW'(-fl) : FW'(fl);
            rem_reg <= '0;
            fnz_reg <= fnz;
        end
        else if (step)
        begin
            mag_reg <= mag_reg << 1;
            if (trial >= {1'b0, n})
            begin
                rem_reg <= NW'(trial - {1'b0, n});
            end
            else
            begin
                rem_reg <= NW'(trial);
            end
        end
        if (fix)
        begin
            i0_reg <= i0_next;
            i1_reg <= i1_next;
        end
    end

    assign i0 = i0_reg;
    assign i1 = i1_reg;

endmodule

// ===== hw/rtl/bts_ctrl.sv =====
`timescale 1ns / 1ps

module bts_ctrl #(
    parameter int STEPS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bts_pkg::bts_stat_t  stat,
    output bts_pkg::bts_cmd_t   cmd
);

    localparam int CW = $clog2(STEPS + 1);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DECODE = 11'b000_0000_0010,
        ST_WSTART = 11'b000_0000_0100,
        ST_WSTEP  = 11'b000_0000_1000,
        ST_WFIX   = 11'b000_0001_0000,
        ST_BASE   = 11'b000_0010_0000,
        ST_READ   = 11'b000_0100_0000,
        ST_DRAIN  = 11'b000_1000_0000,
        ST_GAMMA  = 11'b001_0000_0000,
        ST_WRITE  = 11'b010_0000_0000,
        ST_FINISH = 11'b100_0000_0000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          rd_pend_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Sequence one word through decode, wrap, read, gamma, write and result
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.acc_en   = rd_pend_reg;
        cmd.rd_idx   = cnt_reg[1:0];
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                cnt_next   = '0;
                case (stat.op)
                    bts_pkg::OpStore:  state_next = stat.oob ? ST_FINISH : ST_GAMMA;
                    bts_pkg::OpLoad:   state_next = stat.oob ? ST_FINISH : ST_READ;
                    bts_pkg::OpSample: state_next = ST_WSTART;
                    default:           state_next = ST_IDLE;
                endcase
            end
            ST_WSTART:
            begin
                cmd.wrap_start = 1'b1;
                cnt_next       = '0;
                state_next     = ST_WSTEP;
            end
            ST_WSTEP:
            begin
                cmd.wrap_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    state_next = ST_WFIX;
                end
            end
            ST_WFIX:
            begin
                cmd.wrap_fix = 1'b1;
                state_next   = ST_BASE;
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                cnt_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (stat.op == bts_pkg::OpLoad || cnt_reg == CW'(3))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_GAMMA;
            end
            ST_GAMMA:
            begin
                cmd.gamma  = 1'b1;
                state_next = (stat.op == bts_pkg::OpStore) ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= cmd.rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/bts_dpath.sv =====
`timescale 1ns / 1ps

module bts_dpath #(
    parameter int MAX_WIDTH  = bts_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = bts_pkg::MaxHeightDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bts_pkg::bts_in_t              in_data,
    input  logic                          cfg_wen,
    input  logic [bts_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bts_pkg::CfgDataW-1:0]  cfg_data,
    input  bts_pkg::bts_cmd_t             cmd,
    output bts_pkg::bts_stat_t            stat,
    output bts_pkg::bts_out_t             out_data
);

    localparam int WNW   = $clog2(MAX_WIDTH + 1);
    localparam int HNW   = $clog2(MAX_HEIGHT + 1);
    localparam int NW    = (WNW > HNW) ? WNW : HNW;
    localparam int PXW   = 24 + NW + 1;
    localparam int FW    = PXW - 16;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACCW  = 40;

    bts_pkg::bts_in_t  in_reg;
    bts_pkg::bts_out_t out_reg;

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        srgb_reg;

    logic [WNW-1:0] eff_w;
    logic [HNW-1:0] eff_h;
    logic           oob;
    logic           is_store;

    logic [AW-1:0]         addr_reg;
    logic signed [PXW-1:0] px_reg;
    logic signed [PXW-1:0] py_reg;
    logic [NW-1:0]         x0;
    logic [NW-1:0]         x1;
    logic [NW-1:0]         y0;
    logic [NW-1:0]         y1;
    logic [AW-1:0]         base0_reg;
    logic [AW-1:0]         base1_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         mem_addr;
    logic [16:0]           fxw;
    logic [16:0]           fyw;
    logic [33:0]           wt_reg;
    logic [ACCW-1:0]       acc_reg [4];
    logic [bts_pkg::TexelBits-1:0] mem_rdata;
    logic [bts_pkg::TexelBits-1:0] word_reg;
    logic [15:0]           res_reg [4];
    logic [17:0]           col [4];
    logic [15:0]           gam_res [4];
    logic [7:0]            gam_byte [4];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            srgb_reg   <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bts_pkg::CfgWidth:  width_reg  <= cfg_data;
                bts_pkg::CfgHeight: height_reg <= cfg_data;
                bts_pkg::CfgSrgb:   srgb_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Clamp texture size to 1..max
    always_comb
    begin
        if (width_reg == 9'd0)
        begin
            eff_w = WNW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WNW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WNW'(width_reg);
        end
        if (height_reg == 9'd0)
        begin
            eff_h = HNW'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = HNW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HNW'(height_reg);
        end
    end

    assign oob = (32'(in_reg.texel_x) >= 32'(eff_w)) || (32'(in_reg.texel_y) >= 32'(eff_h));
    assign is_store = (in_reg.opcode == bts_pkg::OpStore);
    assign stat.op  = in_reg.opcode;
    assign stat.oob = oob;

    // Capture the word, then texel address and scaled sample positions
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.decode)
        begin
            addr_reg <= AW'(AW'(in_reg.texel_y) * AW'(eff_w) + AW'(in_reg.texel_x));
            px_reg   <= $signed(PXW'(in_reg.coord_u)) * $signed(PXW'({1'b0, eff_w}))
                        - $signed(PXW'(32768));
            py_reg   <= $signed(PXW'(in_reg.coord_v)) * $signed(PXW'({1'b0, eff_h}))
                        - $signed(PXW'(32768));
        end
    end

    // Wrap floor positions into the texture
    bts_wrap #(.NW(NW), .FW(FW)) u_wrap_x (
        .clk   (clk),
        .start (cmd.wrap_start),
        .step  (cmd.wrap_step),
        .fix   (cmd.wrap_fix),
        .fl    ($signed(px_reg[PXW-1:16])),
        .fnz   (px_reg[15:0] != 16'd0),
        .n     (NW'(eff_w)),
        .i0    (x0),
        .i1    (x1)
    );

    bts_wrap #(.NW(NW), .FW(FW)) u_wrap_y (
        .clk   (clk),
        .start (cmd.wrap_start),
        .step  (cmd.wrap_step),
        .fix   (cmd.wrap_fix),
        .fl    ($signed(py_reg[PXW-1:16])),
        .fnz   (py_reg[15:0] != 16'd0),
        .n     (NW'(eff_h)),
        .i0    (y0),
        .i1    (y1)
    );

    // Row bases, per-tap weights and address
    assign rd_addr = (cmd.rd_idx[1] ? base1_reg : base0_reg)
                     + AW'(cmd.rd_idx[0] ? x1 : x0);
    assign mem_addr = (!cmd.mem_wr && in_reg.opcode == bts_pkg::OpSample) ? rd_addr : addr_reg;
    assign fxw = cmd.rd_idx[0] ? {1'b0, px_reg[15:0]} : 17'h10000 - {1'b0, px_reg[15:0]};
    assign fyw = cmd.rd_idx[1] ? {1'b0, py_reg[15:0]} : 17'h10000 - {1'b0, py_reg[15:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.base)
        begin
            base0_reg <= AW'(AW'(y0) * AW'(eff_w));
            base1_reg <= AW'(AW'(y1) * AW'(eff_w));
        end
        if (cmd.rd_en)
        begin
            wt_reg <= 34'(fxw) * 34'(fyw);
        end
    end

    bts_ram #(.WIDTH(bts_pkg::TexelBits), .DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .addr  (mem_addr),
        .wdata (word_reg),
        .rdata (mem_rdata)
    );

    // Accumulate weighted texels, or take one texel for a load
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (cmd.base)
            begin
                acc_reg[k] <= '0;
            end
            else if (cmd.acc_en)
            begin
                if (in_reg.opcode == bts_pkg::OpLoad)
                begin
                    acc_reg[k] <= {mem_rdata[8*k +: 8], 32'd0};
                end
                else
                begin
                    acc_reg[k] <= acc_reg[k]
                                  + ACCW'(42'(mem_rdata[8*k +: 8]) * 42'(wt_reg));
                end
            end
        end
    end

    // Gamma lanes: forward on reads, inverse on stores
    assign col[0] = in_reg.red_in;
    assign col[1] = in_reg.green_in;
    assign col[2] = in_reg.blue_in;
    assign col[3] = in_reg.alpha_in;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [15:0] res;
            logic [15:0] cx;
            logic [15:0] cv;
            logic        gam;
            res = acc_reg[k][ACCW-1 -: 16];
            cx  = is_store ? col[k][15:0] : res;
            cv  = bts_pkg::curve(is_store, cx);
            gam = srgb_reg && (k < 3);
            gam_res[k] = gam ? cv : res;
            if (col[k][17:16] != 2'd0)
            begin
                gam_byte[k] = 8'hFF;
            end
            else
            begin
                gam_byte[k] = gam ? cv[15:8] : col[k][15:8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gamma)
        begin
            for (int k = 0; k < 4; k++)
            begin
                res_reg[k]            <= gam_res[k];
                word_reg[8*k +: 8]    <= gam_byte[k];
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (is_store || (oob && in_reg.opcode == bts_pkg::OpLoad))
            begin
                out_reg.red_out   <= 16'd0;
                out_reg.green_out <= 16'd0;
                out_reg.blue_out  <= 16'd0;
                out_reg.alpha_out <= 16'd0;
            end
            else
            begin
                out_reg.red_out   <= res_reg[0];
                out_reg.green_out <= res_reg[1];
                out_reg.blue_out  <= res_reg[2];
                out_reg.alpha_out <= res_reg[3];
            end
            out_reg.error <= oob && (in_reg.opcode != bts_pkg::OpSample);
        end
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/bilinear_texture_sampler_core.sv =====
`timescale 1ns / 1ps
//  channel   signals                          moves
//  input     in_valid / in_ready / in_data    one store, load or sample word
//  output    out_valid / out_ready / out_data one result word (none for opcode 3)
//  config    cfg_wen / cfg_index / cfg_data   width, height, srgb; no wait
//
//  A store runs decode, gamma, write; a load decode, read, drain, gamma; an out-of-range load
//  or store goes from decode to the result. A sample's wrap remainder runs one bit a cycle
//  over 18 bits at default size, and its four taps come from one single-ported texel memory.
//  One word is in flight at a time; the result register lets the next word in while it waits.
//  Reset clears control and configuration only; texel memory holds garbage until written.

module bilinear_texture_sampler_core #(
    parameter int MAX_WIDTH  = bts_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = bts_pkg::MaxHeightDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bts_pkg::bts_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bts_pkg::bts_out_t             out_data,
    input  logic                          cfg_wen,
    input  logic [bts_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bts_pkg::CfgDataW-1:0]  cfg_data
);

    localparam int WNW = $clog2(MAX_WIDTH + 1);
    localparam int HNW = $clog2(MAX_HEIGHT + 1);
    localparam int NW  = (WNW > HNW) ? WNW : HNW;
    localparam int FW  = 24 + NW + 1 - 16;

    bts_pkg::bts_cmd_t  cmd;
    bts_pkg::bts_stat_t stat;

    bts_ctrl #(.STEPS(FW)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bts_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

`include "bilinear_texture_sampler_core_assert.svh"

    `BTS_ASSERT_NOW(a_no_overwrite, cmd.out_load, (!out_valid || out_ready), "result overwritten before taken")
    `BTS_ASSERT_NOW(a_rd_wr_excl, cmd.rd_en, !cmd.mem_wr, "texel read and write in one cycle")
    `BTS_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "second word accepted while busy")
    `BTS_ASSERT_NOW(a_write_busy, cmd.mem_wr, (!in_ready && stat.op == bts_pkg::OpStore), "texel write outside a store")

endmodule
